// ----- hdl/ccedit_pkg.sv -----
`default_nettype none

package ccedit_pkg;

    localparam int DEF_ROWS = 32;
    localparam int DEF_COLS = 128;

    localparam int CHAR_W  = 8;
    // signed width for shift amounts and source coordinates, sized for 256 by 256
    localparam int SHIFT_W = 10;
    // unsigned width that holds any dimension up to 256
    localparam int DIM_W   = 9;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_LOW  = 8'd32;
    localparam logic [CHAR_W-1:0] PRINT_HIGH = 8'd126;

    typedef enum logic [2:0] {
        CMD_KEY     = 3'd0,
        CMD_MOVE    = 3'd1,
        CMD_REPLACE = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_UNDO    = 3'd4,
        CMD_READ    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        KEY_PRINT  = 3'd0,
        KEY_LEFT   = 3'd1,
        KEY_RIGHT  = 3'd2,
        KEY_UP     = 3'd3,
        KEY_DOWN   = 3'd4,
        KEY_ESC    = 3'd5,
        KEY_IGNORE = 3'd6
    } key_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_SWEEP,
        ST_KEY,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic run;
        logic move;
    } sweep_ctl_t;

    typedef struct packed {
        logic pend;
        logic ok;
        logic done;
    } sweep_stat_t;

endpackage

`default_nettype wire

// ----- hdl/character_canvas_editor_top.sv -----
`default_nettype none

// sequencing: a key or read cell is handled directly, but the first key of a session
// is preceded by a canvas-to-undo copy pass; replace, clear and undo take one sweep pass;
// move takes a copy pass then a shift pass, one cell per cycle per store port
// throughput: one transaction at a time, in_stall high while one is in flight
// reset: a clearing pass fills both stores with spaces

module character_canvas_editor_top #(
    parameter int ROWS = ccedit_pkg::DEF_ROWS,
    parameter int COLS = ccedit_pkg::DEF_COLS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        command,
    input  wire logic [2:0]        key_kind,
    input  wire logic [7:0]        key_char,
    input  wire logic signed [6:0] row_shift,
    input  wire logic signed [8:0] col_shift,
    input  wire logic [7:0]        old_char,
    input  wire logic [7:0]        new_char,
    input  wire logic [4:0]        cell_row,
    input  wire logic [6:0]        cell_col,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             cell_data,
    output logic [4:0]             cursor_row,
    output logic [6:0]             cursor_col,
    output logic                   editing
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);

    logic                              canvas_we;
    logic [AW-1:0]                     canvas_waddr;
    logic [ccedit_pkg::CHAR_W-1:0]     canvas_wdata;
    logic [AW-1:0]                     canvas_raddr;
    logic [ccedit_pkg::CHAR_W-1:0]     canvas_rdata;
    logic                              undo_we;
    logic [AW-1:0]                     undo_waddr;
    logic [ccedit_pkg::CHAR_W-1:0]     undo_wdata;
    logic [AW-1:0]                     undo_raddr;
    logic [ccedit_pkg::CHAR_W-1:0]     undo_rdata;
    ccedit_pkg::sweep_ctl_t            sw_ctl;
    ccedit_pkg::sweep_stat_t           sw_stat;
    logic signed [ccedit_pkg::SHIFT_W-1:0] sw_dr;
    logic signed [ccedit_pkg::SHIFT_W-1:0] sw_dc;
    logic [AW-1:0]                     sw_rd_addr;
    logic [AW-1:0]                     sw_wr_addr;

    ccedit_ram #(
        .WIDTH (ccedit_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_canvas_ram (
        .clk   (clk),
        .we    (canvas_we),
        .waddr (canvas_waddr),
        .wdata (canvas_wdata),
        .raddr (canvas_raddr),
        .rdata (canvas_rdata)
    );

    ccedit_ram #(
        .WIDTH (ccedit_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_undo_ram (
        .clk   (clk),
        .we    (undo_we),
        .waddr (undo_waddr),
        .wdata (undo_wdata),
        .raddr (undo_raddr),
        .rdata (undo_rdata)
    );

    ccedit_sweep #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sw_ctl),
        .dr      (sw_dr),
        .dc      (sw_dc),
        .rd_addr (sw_rd_addr),
        .wr_addr (sw_wr_addr),
        .stat    (sw_stat)
    );

    ccedit_ctrl #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .key_kind     (key_kind),
        .key_char     (key_char),
        .row_shift    (row_shift),
        .col_shift    (col_shift),
        .old_char     (old_char),
        .new_char     (new_char),
        .cell_row     (cell_row),
        .cell_col     (cell_col),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_data    (cell_data),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .editing      (editing),
        .canvas_we    (canvas_we),
        .canvas_waddr (canvas_waddr),
        .canvas_wdata (canvas_wdata),
        .canvas_raddr (canvas_raddr),
        .canvas_rdata (canvas_rdata),
        .undo_we      (undo_we),
        .undo_waddr   (undo_waddr),
        .undo_wdata   (undo_wdata),
        .undo_raddr   (undo_raddr),
        .undo_rdata   (undo_rdata),
        .sw_ctl       (sw_ctl),
        .sw_dr        (sw_dr),
        .sw_dc        (sw_dc),
        .sw_rd_addr   (sw_rd_addr),
        .sw_wr_addr   (sw_wr_addr),
        .sw_stat      (sw_stat)
    );

endmodule

`default_nettype wire

// ----- hdl/ccedit_ram.sv -----
`default_nettype none

module ccedit_ram #(
    parameter int WIDTH = ccedit_pkg::CHAR_W,
    parameter int DEPTH = ccedit_pkg::DEF_ROWS * ccedit_pkg::DEF_COLS
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/ccedit_sweep.sv -----
`default_nettype none

module ccedit_sweep #(
    parameter int ROWS = ccedit_pkg::DEF_ROWS,
    parameter int COLS = ccedit_pkg::DEF_COLS
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire ccedit_pkg::sweep_ctl_t                  ctl,
    input  wire logic signed [ccedit_pkg::SHIFT_W-1:0]   dr,
    input  wire logic signed [ccedit_pkg::SHIFT_W-1:0]   dc,
    output logic [$clog2(ROWS*COLS)-1:0]                 rd_addr,
    output logic [$clog2(ROWS*COLS)-1:0]                 wr_addr,
    output ccedit_pkg::sweep_stat_t                      stat
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int SW    = ccedit_pkg::SHIFT_W;

    logic [AW-1:0] idx_reg, idx_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          drain_reg, drain_next;
    logic          pend_reg, pend_next;
    logic          ok_reg, ok_next;
    logic [AW-1:0] wa_reg, wa_next;

    logic signed [SW-1:0] src_r;
    logic signed [SW-1:0] src_c;
    logic                 src_ok;
    logic [AW-1:0]        src_addr;
    logic                 issue;
    logic                 last;

    // source cell of a shift: destination minus the shift amount
    always_comb
    begin
        src_r    = $signed(SW'(row_reg)) - dr;
        src_c    = $signed(SW'(col_reg)) - dc;
        src_ok   = !src_r[SW-1] && (src_r < $signed(SW'(ROWS)))
                && !src_c[SW-1] && (src_c < $signed(SW'(COLS)));
        src_addr = AW'(src_r[RW-1:0]) * AW'(COLS) + AW'(src_c[CW-1:0]);
    end

    assign issue   = ctl.run && !drain_reg;
    assign last    = (idx_reg == AW'(DEPTH - 1));
    assign rd_addr = (ctl.move && src_ok) ? src_addr : idx_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        drain_next = 1'b0;
        pend_next  = 1'b0;
        ok_next    = ok_reg;
        wa_next    = wa_reg;
        if (issue)
        begin
            pend_next = 1'b1;
            wa_next   = idx_reg;
            ok_next   = !ctl.move || src_ok;
            if (last)
            begin
                idx_next   = '0;
                row_next   = '0;
                col_next   = '0;
                drain_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                if (col_reg == CW'(COLS - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            drain_reg <= drain_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        wa_reg <= wa_next;
    end

    assign wr_addr   = wa_reg;
    assign stat.pend = pend_reg;
    assign stat.ok   = ok_reg;
    // last write of the pass goes out in this cycle
    assign stat.done = drain_reg;

endmodule

`default_nettype wire

// ----- hdl/ccedit_ctrl.sv -----
`default_nettype none

module ccedit_ctrl #(
    parameter int ROWS = ccedit_pkg::DEF_ROWS,
    parameter int COLS = ccedit_pkg::DEF_COLS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [2:0]                             command,
    input  wire logic [2:0]                             key_kind,
    input  wire logic [7:0]                             key_char,
    input  wire logic signed [6:0]                      row_shift,
    input  wire logic signed [8:0]                      col_shift,
    input  wire logic [7:0]                             old_char,
    input  wire logic [7:0]                             new_char,
    input  wire logic [4:0]                             cell_row,
    input  wire logic [6:0]                             cell_col,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [7:0]                                  cell_data,
    output logic [4:0]                                  cursor_row,
    output logic [6:0]                                  cursor_col,
    output logic                                        editing,
    output logic                                        canvas_we,
    output logic [$clog2(ROWS*COLS)-1:0]                canvas_waddr,
    output logic [ccedit_pkg::CHAR_W-1:0]               canvas_wdata,
    output logic [$clog2(ROWS*COLS)-1:0]                canvas_raddr,
    input  wire logic [ccedit_pkg::CHAR_W-1:0]          canvas_rdata,
    output logic                                        undo_we,
    output logic [$clog2(ROWS*COLS)-1:0]                undo_waddr,
    output logic [ccedit_pkg::CHAR_W-1:0]               undo_wdata,
    output logic [$clog2(ROWS*COLS)-1:0]                undo_raddr,
    input  wire logic [ccedit_pkg::CHAR_W-1:0]          undo_rdata,
    output ccedit_pkg::sweep_ctl_t                      sw_ctl,
    output logic signed [ccedit_pkg::SHIFT_W-1:0]       sw_dr,
    output logic signed [ccedit_pkg::SHIFT_W-1:0]       sw_dc,
    input  wire logic [$clog2(ROWS*COLS)-1:0]           sw_rd_addr,
    input  wire logic [$clog2(ROWS*COLS)-1:0]           sw_wr_addr,
    input  wire ccedit_pkg::sweep_stat_t                sw_stat
);

    localparam int AW = $clog2(ROWS * COLS);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int SW = ccedit_pkg::SHIFT_W;
    localparam int DW = ccedit_pkg::DIM_W;

    ccedit_pkg::state_t state_reg, state_next;
    ccedit_pkg::cmd_t   op_reg, op_next;
    logic [2:0]         kind_reg, kind_next;
    logic [7:0]         char_reg, char_next;
    logic [7:0]         old_reg, old_next;
    logic [7:0]         new_reg, new_next;
    logic signed [SW-1:0] dr_reg, dr_next;
    logic signed [SW-1:0] dc_reg, dc_next;
    logic [RW-1:0]      cy_reg, cy_next;
    logic [CW-1:0]      cx_reg, cx_next;
    logic               edit_reg, edit_next;
    logic               rdok_reg, rdok_next;
    logic [7:0]         data_reg, data_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_data_reg;
    logic [4:0]         out_cy_reg;
    logic [6:0]         out_cx_reg;
    logic               out_edit_reg;

    logic                 out_load;
    logic signed [SW-1:0] rs, cs, lim_r, lim_c, dr_sat, dc_sat;
    logic [AW-1:0]        cell_addr;
    logic [AW-1:0]        cursor_addr;
    logic                 cell_in;
    logic                 printable;

    assign out_load = (state_reg == ccedit_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != ccedit_pkg::ST_IDLE);

    // shift amounts saturate at the canvas size
    always_comb
    begin
        rs     = {{(SW-7){row_shift[6]}}, row_shift};
        cs     = {{(SW-9){col_shift[8]}}, col_shift};
        lim_r  = $signed(SW'(ROWS));
        lim_c  = $signed(SW'(COLS));
        dr_sat = (rs > lim_r) ? lim_r : ((rs < -lim_r) ? -lim_r : rs);
        dc_sat = (cs > lim_c) ? lim_c : ((cs < -lim_c) ? -lim_c : cs);
    end

    assign cell_in     = (DW'(cell_row) < DW'(ROWS)) && (DW'(cell_col) < DW'(COLS));
    assign cell_addr   = AW'(cell_row) * AW'(COLS) + AW'(cell_col);
    assign cursor_addr = AW'(cy_reg) * AW'(COLS) + AW'(cx_reg);
    assign printable   = (char_reg >= ccedit_pkg::PRINT_LOW)
                      && (char_reg <= ccedit_pkg::PRINT_HIGH);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ccedit_pkg::ST_INIT:
            begin
                if (sw_stat.done)
                begin
                    state_next = ccedit_pkg::ST_IDLE;
                end
            end
            ccedit_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (ccedit_pkg::cmd_t'(command)) inside
                        ccedit_pkg::CMD_KEY:
                        begin
                            state_next = edit_reg ? ccedit_pkg::ST_KEY : ccedit_pkg::ST_COPY;
                        end
                        ccedit_pkg::CMD_MOVE:
                        begin
                            state_next = ccedit_pkg::ST_COPY;
                        end
                        ccedit_pkg::CMD_REPLACE, ccedit_pkg::CMD_CLEAR, ccedit_pkg::CMD_UNDO:
                        begin
                            state_next = ccedit_pkg::ST_SWEEP;
                        end
                        ccedit_pkg::CMD_READ:
                        begin
                            state_next = ccedit_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = ccedit_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ccedit_pkg::ST_COPY:
            begin
                if (sw_stat.done)
                begin
                    state_next = (op_reg == ccedit_pkg::CMD_KEY) ? ccedit_pkg::ST_KEY
                                                                 : ccedit_pkg::ST_SWEEP;
                end
            end
            ccedit_pkg::ST_SWEEP:
            begin
                if (sw_stat.done)
                begin
                    state_next = ccedit_pkg::ST_DONE;
                end
            end
            ccedit_pkg::ST_KEY:
            begin
                state_next = ccedit_pkg::ST_DONE;
            end
            ccedit_pkg::ST_READ:
            begin
                state_next = ccedit_pkg::ST_DONE;
            end
            ccedit_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ccedit_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        op_next      = op_reg;
        kind_next    = kind_reg;
        char_next    = char_reg;
        old_next     = old_reg;
        new_next     = new_reg;
        dr_next      = dr_reg;
        dc_next      = dc_reg;
        cy_next      = cy_reg;
        cx_next      = cx_reg;
        edit_next    = edit_reg;
        rdok_next    = rdok_reg;
        data_next    = data_reg;
        canvas_we    = 1'b0;
        canvas_waddr = sw_wr_addr;
        canvas_wdata = ccedit_pkg::SPACE_CHAR;
        canvas_raddr = sw_rd_addr;
        undo_we      = 1'b0;
        undo_waddr   = sw_wr_addr;
        undo_wdata   = ccedit_pkg::SPACE_CHAR;
        undo_raddr   = sw_rd_addr;
        sw_ctl.run   = 1'b0;
        sw_ctl.move  = 1'b0;

        unique case (state_reg)
            ccedit_pkg::ST_INIT:
            begin
                // clearing pass: both stores to spaces
                sw_ctl.run = 1'b1;
                canvas_we  = sw_stat.pend;
                undo_we    = sw_stat.pend;
            end
            ccedit_pkg::ST_IDLE:
            begin
                canvas_raddr = cell_addr;
                if (in_valid)
                begin
                    op_next   = ccedit_pkg::cmd_t'(command);
                    kind_next = key_kind;
                    char_next = key_char;
                    old_next  = old_char;
                    new_next  = new_char;
                    dr_next   = dr_sat;
                    dc_next   = dc_sat;
                    rdok_next = cell_in;
                    data_next = '0;
                    case (ccedit_pkg::cmd_t'(command)) inside
                        ccedit_pkg::CMD_KEY:
                        begin
                            if (!edit_reg)
                            begin
                                cy_next   = '0;
                                cx_next   = '0;
                                edit_next = 1'b1;
                            end
                        end
                        ccedit_pkg::CMD_MOVE, ccedit_pkg::CMD_REPLACE, ccedit_pkg::CMD_CLEAR,
                        ccedit_pkg::CMD_UNDO:
                        begin
                            edit_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ccedit_pkg::ST_COPY:
            begin
                sw_ctl.run = 1'b1;
                undo_we    = sw_stat.pend;
                undo_wdata = canvas_rdata;
            end
            ccedit_pkg::ST_SWEEP:
            begin
                sw_ctl.run  = 1'b1;
                sw_ctl.move = (op_reg == ccedit_pkg::CMD_MOVE);
                case (op_reg)
                    ccedit_pkg::CMD_REPLACE:
                    begin
                        canvas_we    = sw_stat.pend;
                        canvas_wdata = (canvas_rdata == old_reg) ? new_reg : canvas_rdata;
                        undo_we      = sw_stat.pend;
                        undo_wdata   = canvas_rdata;
                    end
                    ccedit_pkg::CMD_CLEAR:
                    begin
                        canvas_we  = sw_stat.pend;
                        undo_we    = sw_stat.pend;
                        undo_wdata = canvas_rdata;
                    end
                    ccedit_pkg::CMD_UNDO:
                    begin
                        canvas_we    = sw_stat.pend;
                        canvas_wdata = undo_rdata;
                    end
                    ccedit_pkg::CMD_MOVE:
                    begin
                        // the undo store already holds the old canvas
                        canvas_we    = sw_stat.pend;
                        canvas_wdata = sw_stat.ok ? undo_rdata : ccedit_pkg::SPACE_CHAR;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ccedit_pkg::ST_KEY:
            begin
                canvas_waddr = cursor_addr;
                canvas_wdata = char_reg;
                case (kind_reg)
                    ccedit_pkg::KEY_PRINT:
                    begin
                        canvas_we = printable;
                    end
                    ccedit_pkg::KEY_LEFT:
                    begin
                        if (cx_reg != '0)
                        begin
                            cx_next = cx_reg - 1'b1;
                        end
                    end
                    ccedit_pkg::KEY_RIGHT:
                    begin
                        if (cx_reg != CW'(COLS - 1))
                        begin
                            cx_next = cx_reg + 1'b1;
                        end
                    end
                    ccedit_pkg::KEY_UP:
                    begin
                        if (cy_reg != '0)
                        begin
                            cy_next = cy_reg - 1'b1;
                        end
                    end
                    ccedit_pkg::KEY_DOWN:
                    begin
                        if (cy_reg != RW'(ROWS - 1))
                        begin
                            cy_next = cy_reg + 1'b1;
                        end
                    end
                    ccedit_pkg::KEY_ESC:
                    begin
                        edit_next = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ccedit_pkg::ST_READ:
            begin
                data_next = rdok_reg ? canvas_rdata : '0;
            end
            ccedit_pkg::ST_DONE:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ccedit_pkg::ST_INIT;
            cy_reg        <= '0;
            cx_reg        <= '0;
            edit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cy_reg        <= cy_next;
            cx_reg        <= cx_next;
            edit_reg      <= edit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        kind_reg <= kind_next;
        char_reg <= char_next;
        old_reg  <= old_next;
        new_reg  <= new_next;
        dr_reg   <= dr_next;
        dc_reg   <= dc_next;
        rdok_reg <= rdok_next;
        data_reg <= data_next;
        if (out_load)
        begin
            out_data_reg <= data_reg;
            out_cy_reg   <= 5'(cy_reg);
            out_cx_reg   <= 7'(cx_reg);
            out_edit_reg <= edit_reg;
        end
    end

    assign sw_dr      = dr_reg;
    assign sw_dc      = dc_reg;
    assign out_valid  = out_valid_reg;
    assign cell_data  = out_data_reg;
    assign cursor_row = out_cy_reg;
    assign cursor_col = out_cx_reg;
    assign editing    = out_edit_reg;

endmodule

`default_nettype wire
